// ===== hw/rtl/bounded_deque_with_index_access_unit_macros.svh =====
// Assertion macros for the bounded deque unit.
`ifndef BOUNDED_DEQUE_WITH_INDEX_ACCESS_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INDEX_ACCESS_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define BDQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define BDQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDQ_ASSERT_IMP(label, ante, cons, msg)
`define BDQ_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/bdq_pkg.sv =====
// Shared constants and types for the bounded deque unit.
package bdq_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned OP_W      = 3;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned CNT_OUT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_POP_FRONT  = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_READ       = 3'd4,
		OP_WRITE      = 3'd5,
		OP_SEARCH     = 3'd6,
		OP_REMOVE     = 3'd7
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADIDX = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_EXEC   = 3'd1,
		S_RDWAIT = 3'd2,
		S_WALK   = 3'd3,
		S_DONE   = 3'd4
	} state_t;

endpackage

// ===== hw/rtl/bdq_req_if.sv =====
// Request channel: opcode, position and data value.
interface bdq_req_if;
	import bdq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] data_value;

	modport source(output valid, output opcode, output position, output data_value,
		input ready);
	modport sink(input valid, input opcode, input position, input data_value,
		output ready);
endinterface

// ===== hw/rtl/bdq_rsp_if.sv =====
// Response channel: read value, found flag, status and entry count.
interface bdq_rsp_if;
	import bdq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic                     found;
	logic [STAT_W-1:0]        status;
	logic [CNT_OUT_W-1:0]     entry_count;

	modport source(output valid, output read_value, output found, output status,
		output entry_count, input ready);
	modport sink(input valid, input read_value, input found, input status,
		input entry_count, output ready);
endinterface

// ===== hw/rtl/bounded_deque_with_index_access_unit.sv =====
// Bounded deque of signed words: ring store in one synchronous memory, head and count.
// Push, pop and write pass from the accepted request beat through EXEC and DONE to the
// response beat; read adds RDWAIT for one memory read; search and remove-all add WALK,
// which walks the store one entry per cycle through the single memory read port.
// One request is in flight at a time; a new beat is taken once the previous result
// sits in the response register. Reset empties the deque (head and count zero).
`include "bounded_deque_with_index_access_unit_macros.svh"

module bounded_deque_with_index_access_unit #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	bdq_req_if.sink  req,
	bdq_rsp_if.source rsp
);
	import bdq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
		input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] a);
		return (a == LAST_SLOT) ? '0 : a + AW'(1);
	endfunction

	// ring store
	logic signed [DATA_W-1:0] entry_store_q [DEPTH];
	logic signed [DATA_W-1:0] mem_rdata_q;
	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic [AW-1:0]            mem_raddr;
	logic signed [DATA_W-1:0] mem_wdata;

	state_t state_q, state_d;

	opcode_t                  op_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic [AW-1:0]            head_q;
	logic [CW-1:0]            count_q;

	// walk pointers: reads run ahead of compacted writes
	logic [CW-1:0]            rd_idx_q;
	logic [AW-1:0]            rd_slot_q;
	logic [AW-1:0]            wr_slot_q;
	logic [CW-1:0]            keep_q;
	logic                     walk_vld_s1;

	logic signed [DATA_W-1:0] res_rd_q;
	logic                     found_q;
	status_t                  res_status_q;

	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] rsp_read_value_q;
	logic                     rsp_found_q;
	status_t                  rsp_status_q;
	logic [CNT_OUT_W-1:0]     rsp_count_q;

	logic          is_full;
	logic          is_empty;
	logic          pos_bad;
	logic [AW-1:0] slot_pos;
	logic [AW-1:0] slot_back;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic          walk_issue;
	logic          walk_done;
	logic          match_val;
	logic          out_free;
	logic          req_beat;

	assign is_full    = (count_q == DEPTH_C);
	assign is_empty   = (count_q == '0);
	assign pos_bad    = (PW'(pos_q) >= PW'(count_q));
	assign slot_pos   = wrap_add(head_q, AW'(pos_q));
	assign slot_back  = wrap_add(head_q, AW'(count_q));
	assign head_dec   = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
	assign head_inc   = slot_next(head_q);
	assign walk_issue = (state_q == S_WALK) && (rd_idx_q != count_q);
	assign walk_done  = (state_q == S_WALK) && !walk_issue && !walk_vld_s1;
	assign match_val  = (mem_rdata_q == val_q);
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign req_beat   = req.valid && req.ready;

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_value  = rsp_read_value_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_store_q[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= entry_store_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = wr_slot_q;
		mem_wdata = mem_rdata_q;
		mem_raddr = (state_q == S_WALK) ? rd_slot_q : slot_pos;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (op_q)
					OP_PUSH_FRONT: begin
						if (!is_full) begin
							mem_we    = 1'b1;
							mem_waddr = head_dec;
							mem_wdata = val_q;
						end
					end
					OP_PUSH_BACK: begin
						if (!is_full) begin
							mem_we    = 1'b1;
							mem_waddr = slot_back;
							mem_wdata = val_q;
						end
					end
					OP_WRITE: begin
						if (!pos_bad) begin
							mem_we    = 1'b1;
							mem_waddr = slot_pos;
							mem_wdata = val_q;
						end
					end
					OP_READ: begin
						if (!pos_bad) begin
							state_d = S_RDWAIT;
						end
					end
					OP_SEARCH, OP_REMOVE: begin
						if (!is_empty) begin
							state_d = S_WALK;
						end
					end
					default: ;
				endcase
			end
			S_RDWAIT: state_d = S_DONE;
			S_WALK: begin
				// survivors are written back at the compacted slot
				if (walk_vld_s1 && !match_val && (op_q == OP_REMOVE)) begin
					mem_we = 1'b1;
				end
				if (walk_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			walk_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			walk_vld_s1 <= walk_issue;
			if (state_q == S_EXEC) begin
				case (op_q)
					OP_PUSH_FRONT: begin
						if (!is_full) begin
							head_q  <= head_dec;
							count_q <= count_q + CW'(1);
						end
					end
					OP_POP_FRONT: begin
						if (!is_empty) begin
							head_q  <= head_inc;
							count_q <= count_q - CW'(1);
						end
					end
					OP_PUSH_BACK: begin
						if (!is_full) begin
							count_q <= count_q + CW'(1);
						end
					end
					OP_POP_BACK: begin
						if (!is_empty) begin
							count_q <= count_q - CW'(1);
						end
					end
					default: ;
				endcase
			end
			if (walk_done && (op_q == OP_REMOVE)) begin
				count_q <= keep_q;
			end
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_beat) begin
			op_q  <= opcode_t'(req.opcode);
			pos_q <= req.position;
			val_q <= req.data_value;
		end
		case (state_q)
			S_EXEC: begin
				res_rd_q  <= '0;
				found_q   <= 1'b0;
				rd_idx_q  <= '0;
				keep_q    <= '0;
				rd_slot_q <= head_q;
				wr_slot_q <= head_q;
				case (op_q)
					OP_PUSH_FRONT, OP_PUSH_BACK:
						res_status_q <= is_full ? ST_FULL : ST_OK;
					OP_POP_FRONT, OP_POP_BACK, OP_REMOVE:
						res_status_q <= is_empty ? ST_EMPTY : ST_OK;
					OP_READ, OP_WRITE:
						res_status_q <= pos_bad ? ST_BADIDX : ST_OK;
					default:
						res_status_q <= ST_OK;
				endcase
			end
			S_RDWAIT: res_rd_q <= mem_rdata_q;
			S_WALK: begin
				if (walk_issue) begin
					rd_idx_q  <= rd_idx_q + CW'(1);
					rd_slot_q <= slot_next(rd_slot_q);
				end
				if (walk_vld_s1) begin
					if (match_val) begin
						found_q <= 1'b1;
					end else if (op_q == OP_REMOVE) begin
						wr_slot_q <= slot_next(wr_slot_q);
						keep_q    <= keep_q + CW'(1);
					end
				end
			end
			default: ;
		endcase
		if ((state_q == S_DONE) && out_free) begin
			rsp_read_value_q <= res_rd_q;
			rsp_found_q      <= found_q;
			rsp_status_q     <= res_status_q;
			rsp_count_q      <= CNT_OUT_W'(count_q);
		end
	end

	`BDQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= DEPTH_C, "count above depth")
	`BDQ_ASSERT_IMP(a_keep_behind, state_q == S_WALK, keep_q <= rd_idx_q, "compaction passed read")
	`BDQ_ASSERT_IMP(a_s1_in_walk, walk_vld_s1, state_q == S_WALK, "walk data outside walk")
	`BDQ_ASSERT_NXT(a_beat_exec, req_beat, state_q == S_EXEC, "accepted beat not executed")
	`BDQ_ASSERT_NXT(a_idle_hold, state_q == S_IDLE, $stable(count_q) && $stable(head_q), "state moved while idle")

endmodule
